// ===== src/aenc_pkg.sv =====
// Shared types and constants of the 16-bit arithmetic encoder.
package aenc_pkg;

    localparam int TABLE_DEPTH_DEF = 32;
    localparam int MAX_BYTES_DEF   = 15;

    localparam int SYM_W   = 5;
    localparam int BOUND_W = 16;
    localparam int RANGE_W = BOUND_W + 1;
    localparam int PROD_W  = BOUND_W + RANGE_W;
    localparam int CNT_W   = 5;

    localparam logic [BOUND_W-1:0] TOTAL_RESET = 16'h3FEE;
    localparam logic [BOUND_W-1:0] HALF        = 16'h8000;
    localparam logic [BOUND_W-1:0] QUARTER     = 16'h4000;
    localparam logic [BOUND_W-1:0] THREE_Q     = 16'hC000;
    localparam logic [BOUND_W-1:0] ALL_ONES    = 16'hFFFF;
    localparam logic [7:0]         BYTE_MSB    = 8'h80;
    localparam logic [3:0]         BITS_FULL   = 4'd8;
    localparam logic [5:0]         DIV_STEPS   = 6'd33;
    localparam logic [5:0]         GUARD_LIMIT = 6'd40;
    localparam logic [CNT_W-1:0]   BYTES_SAT   = 5'd31;
    localparam logic [7:0]         PEND_SAT    = 8'd255;

    typedef enum logic [1:0] {
        ACT_LOAD   = 2'd0,
        ACT_START  = 2'd1,
        ACT_ENCODE = 2'd2,
        ACT_FINISH = 2'd3
    } action_t;

    // Renormalization step chosen from the current bounds
    typedef enum logic [1:0] {
        RN_STOP  = 2'd0,
        RN_E3    = 2'd1,
        RN_EMIT0 = 2'd2,
        RN_EMIT1 = 2'd3
    } renorm_t;

    typedef struct packed {
        logic accept;     // request taken from the item channel
        logic rd_upper;   // read table entry s-1
        logic mul_upper;  // scale upper entry, read entry s
        logic mul_lower;  // scale lower entry, arm divider
        logic div_step;   // one quotient bit for both divisions
        logic update;     // new bounds from quotients
        logic e3;         // underflow step
        logic emit;       // emit step: bit plus bound shift
        logic drain;      // one pending bit
        logic fin_put;    // final 1 bit
        logic fin_part;   // flush partial byte
        logic fin_last;   // terminating zero byte
    } cmd_t;

    typedef struct packed {
        renorm_t rn;
        logic    guard_done;
        logic    pending_zero;
        logic    pending_one;
        logic    put_push;    // next bit completes a byte that gets stored
        logic    part_push;   // partial byte is nonzero and will be sent
        logic    out_free;    // output register can take a byte
        logic    div_last;
    } status_t;

endpackage

// ===== src/aenc_if.sv =====
// Handshake channel interfaces of the arithmetic encoder.
interface aenc_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [4:0]  symbol;
    logic [15:0] table_value;

    modport source (output valid, action, symbol, table_value, input ready);
    modport sink   (input valid, action, symbol, table_value, output ready);
endinterface

interface aenc_code_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       is_last;

    modport source (output valid, out_byte, is_last, input ready);
    modport sink   (input valid, out_byte, is_last, output ready);
endinterface

interface aenc_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] total_count;

    modport source (output valid, total_count, input ready);
    modport sink   (input valid, total_count, output ready);
endinterface

// ===== src/aenc_ctrl.sv =====
// Sequencing state machine of the arithmetic encoder.
module aenc_ctrl
    import aenc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [1:0] in_action,
    output logic       in_ready,
    input  status_t    status,
    output cmd_t       cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_UP,
        S_MUL_UP,
        S_MUL_LO,
        S_DIV,
        S_UPDATE,
        S_RENORM,
        S_DRAIN,
        S_FIN_PUT,
        S_FIN_DRAIN,
        S_FIN_PART,
        S_FIN_LAST
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   put_ok;

    assign put_ok   = !status.put_push || status.out_free;
    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    unique case (action_t'(in_action))
                        ACT_ENCODE: state_next = S_RD_UP;
                        ACT_FINISH: state_next = S_FIN_PUT;
                        ACT_LOAD, ACT_START: state_next = S_IDLE;
                    endcase
                end
            end
            S_RD_UP:
            begin
                cmd.rd_upper = 1'b1;
                state_next   = S_MUL_UP;
            end
            S_MUL_UP:
            begin
                cmd.mul_upper = 1'b1;
                state_next    = S_MUL_LO;
            end
            S_MUL_LO:
            begin
                cmd.mul_lower = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                    state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = S_RENORM;
            end
            S_RENORM:
            begin
                if (status.guard_done)
                    state_next = S_IDLE;
                else
                begin
                    unique case (status.rn)
                        RN_STOP: state_next = S_IDLE;
                        RN_E3:   cmd.e3 = 1'b1;
                        RN_EMIT0, RN_EMIT1:
                        begin
                            if (put_ok)
                            begin
                                cmd.emit = 1'b1;
                                if (!status.pending_zero)
                                    state_next = S_DRAIN;
                            end
                        end
                    endcase
                end
            end
            S_DRAIN:
            begin
                if (put_ok)
                begin
                    cmd.drain = 1'b1;
                    if (status.pending_one)
                        state_next = S_RENORM;
                end
            end
            S_FIN_PUT:
            begin
                if (put_ok)
                begin
                    cmd.fin_put = 1'b1;
                    state_next  = status.pending_zero ? S_FIN_PART : S_FIN_DRAIN;
                end
            end
            S_FIN_DRAIN:
            begin
                if (put_ok)
                begin
                    cmd.drain = 1'b1;
                    if (status.pending_one)
                        state_next = S_FIN_PART;
                end
            end
            S_FIN_PART:
            begin
                if (!status.part_push || status.out_free)
                begin
                    cmd.fin_part = 1'b1;
                    state_next   = S_FIN_LAST;
                end
            end
            S_FIN_LAST:
            begin
                if (status.out_free)
                begin
                    cmd.fin_last = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ===== src/aenc_datapath.sv =====
// Bounds, count table, dividers, bit packer and output register of the encoder.
module aenc_datapath
    import aenc_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int MAX_BYTES   = MAX_BYTES_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               cmd,
    output status_t            status,
    input  logic [1:0]         in_action,
    input  logic [SYM_W-1:0]   in_symbol,
    input  logic [BOUND_W-1:0] in_table_value,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [BOUND_W-1:0] cfg_total_count,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [7:0]         out_byte,
    output logic               out_last
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    logic [BOUND_W-1:0] mem [TABLE_DEPTH];

    logic [BOUND_W-1:0] total_reg;
    logic [BOUND_W-1:0] high_reg;
    logic [BOUND_W-1:0] low_reg;
    logic [7:0]         pend_reg;
    logic [7:0]         shift_reg;
    logic [3:0]         bits_reg;
    logic [CNT_W-1:0]   bytes_reg;
    logic               bit_reg;
    logic [SYM_W-1:0]   sym_reg;
    logic [RANGE_W-1:0] range_reg;
    logic [PROD_W-1:0]  prod_up_reg;
    logic [PROD_W-1:0]  prod_lo_reg;
    logic [BOUND_W-1:0] rem_up_reg;
    logic [BOUND_W-1:0] rem_lo_reg;
    logic [5:0]         div_cnt_reg;
    logic [5:0]         guard_reg;
    logic [BOUND_W-1:0] rd_data_reg;
    logic               rd_zero_reg;
    logic               out_valid_reg;
    logic [7:0]         out_byte_reg;
    logic               out_last_reg;

    action_t            act;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [SYM_W-1:0]   rd_idx;
    logic               rd_en;
    logic               rd_in_range;
    logic [AW-1:0]      rd_addr;
    logic [BOUND_W-1:0] tot;
    logic [BOUND_W-1:0] tbl_val;
    logic [BOUND_W-1:0] upper_sel;
    logic [RANGE_W-1:0] ru_up;
    logic [RANGE_W-1:0] ru_lo;
    logic               ge_up;
    logic               ge_lo;
    renorm_t            rn;
    logic [BOUND_W-1:0] offs;
    logic [BOUND_W-1:0] high_add;
    logic [BOUND_W-1:0] low_add;
    logic               put_en;
    logic               put_val;
    logic [7:0]         shift_put;
    logic               byte_done;
    logic               store_ok;
    logic [7:0]         part_val;
    logic               part_push;
    logic               put_push;
    logic               out_load;
    logic [7:0]         out_load_byte;
    logic               out_free;
    logic [CNT_W-1:0]   bytes_inc;

    assign act       = action_t'(in_action);
    assign cfg_ready = 1'b1;

    // Table write on a load request, silently dropped past the table end
    assign wr_en   = cmd.accept && (act == ACT_LOAD) && (32'(in_symbol) < TABLE_DEPTH);
    assign wr_addr = AW'(in_symbol);

    assign rd_idx      = cmd.rd_upper ? (sym_reg - SYM_W'(1)) : sym_reg;
    assign rd_en       = cmd.rd_upper || cmd.mul_upper;
    assign rd_in_range = (32'(rd_idx) < TABLE_DEPTH);
    assign rd_addr     = AW'(rd_idx);

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= in_table_value;
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
            rd_zero_reg <= !rd_in_range;
        end
    end

    assign tot       = (total_reg == '0) ? BOUND_W'(1) : total_reg;
    assign tbl_val   = rd_zero_reg ? '0 : rd_data_reg;
    assign upper_sel = (sym_reg == '0) ? total_reg : tbl_val;

    // One restoring-division step on each of the two scaled products
    assign ru_up = {rem_up_reg, prod_up_reg[PROD_W-1]};
    assign ru_lo = {rem_lo_reg, prod_lo_reg[PROD_W-1]};
    assign ge_up = (ru_up >= {1'b0, tot});
    assign ge_lo = (ru_lo >= {1'b0, tot});

    // Renormalization decision
    always_comb
    begin
        if (high_reg >= HALF)
        begin
            if (low_reg >= HALF)
                rn = RN_EMIT1;
            else if (low_reg < QUARTER || high_reg >= THREE_Q)
                rn = RN_STOP;
            else
                rn = RN_E3;
        end
        else
            rn = RN_EMIT0;
    end

    always_comb
    begin
        unique case (rn)
            RN_E3:    offs = THREE_Q;
            RN_EMIT1: offs = HALF;
            RN_EMIT0, RN_STOP: offs = '0;
        endcase
    end

    assign high_add = high_reg + offs;
    assign low_add  = low_reg + offs;

    // Bit packer, LSB first
    assign put_en    = cmd.emit || cmd.drain || cmd.fin_put;
    assign put_val   = cmd.emit ? (rn == RN_EMIT1) : (cmd.drain ? !bit_reg : 1'b1);
    assign shift_put = (put_val ? BYTE_MSB : 8'h00) | (shift_reg >> 1);
    assign byte_done = (bits_reg == 4'd1);
    assign store_ok  = (bytes_reg < CNT_W'(MAX_BYTES));
    assign put_push  = byte_done && store_ok;
    assign part_val  = shift_reg >> bits_reg;
    assign part_push = (bits_reg < BITS_FULL) && (part_val != '0);
    assign bytes_inc = (bytes_reg != BYTES_SAT) ? bytes_reg + CNT_W'(1) : bytes_reg;

    assign out_free = !out_valid_reg || out_ready;
    assign out_load = (put_en && put_push) || (cmd.fin_part && part_push) || cmd.fin_last;

    always_comb
    begin
        priority if (cmd.fin_last)
            out_load_byte = '0;
        else if (cmd.fin_part)
            out_load_byte = part_val;
        else
            out_load_byte = shift_put;
    end

    // Coder state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= TOTAL_RESET;
            high_reg  <= ALL_ONES;
            low_reg   <= '0;
            pend_reg  <= '0;
            shift_reg <= '0;
            bits_reg  <= BITS_FULL;
            bytes_reg <= '0;
            bit_reg   <= 1'b0;
            guard_reg <= '0;
        end
        else
        begin
            if (cfg_valid)
                total_reg <= cfg_total_count;

            priority if (cmd.accept && act == ACT_START)
            begin
                high_reg  <= ALL_ONES;
                low_reg   <= '0;
                pend_reg  <= '0;
                shift_reg <= '0;
                bits_reg  <= BITS_FULL;
                bytes_reg <= '0;
            end
            else if (cmd.update)
            begin
                high_reg  <= prod_up_reg[BOUND_W-1:0] + low_reg - BOUND_W'(1);
                low_reg   <= prod_lo_reg[BOUND_W-1:0] + low_reg;
                guard_reg <= '0;
            end
            else if (cmd.e3 || cmd.emit)
            begin
                high_reg  <= {high_add[BOUND_W-2:0], 1'b1};
                low_reg   <= {low_add[BOUND_W-2:0], 1'b0};
                guard_reg <= guard_reg + 6'd1;
                if (cmd.e3 && pend_reg != PEND_SAT)
                    pend_reg <= pend_reg + 8'd1;
            end
            else if (cmd.fin_part)
            begin
                if (bits_reg < BITS_FULL)
                    shift_reg <= part_val;
                if (part_push)
                    bytes_reg <= bytes_inc;
            end
            else if (cmd.fin_last)
                bytes_reg <= bytes_inc;

            if (put_en)
            begin
                shift_reg <= shift_put;
                bits_reg  <= byte_done ? BITS_FULL : bits_reg - 4'd1;
                if (put_push)
                    bytes_reg <= bytes_inc;
                if (cmd.emit || cmd.fin_put)
                    bit_reg <= put_val;
                if (cmd.drain)
                    pend_reg <= pend_reg - 8'd1;
            end
        end
    end

    // Scaling and division
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            div_cnt_reg <= '0;
        else if (cmd.mul_lower)
            div_cnt_reg <= DIV_STEPS;
        else if (cmd.div_step)
            div_cnt_reg <= div_cnt_reg - 6'd1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept && act == ACT_ENCODE)
        begin
            sym_reg   <= in_symbol;
            range_reg <= RANGE_W'(high_reg) - RANGE_W'(low_reg) + RANGE_W'(1);
        end
        if (cmd.mul_upper)
            prod_up_reg <= PROD_W'(upper_sel) * PROD_W'(range_reg);
        if (cmd.mul_lower)
        begin
            prod_lo_reg <= PROD_W'(tbl_val) * PROD_W'(range_reg);
            rem_up_reg  <= '0;
            rem_lo_reg  <= '0;
        end
        if (cmd.div_step)
        begin
            rem_up_reg  <= ge_up ? BOUND_W'(ru_up - {1'b0, tot}) : ru_up[BOUND_W-1:0];
            rem_lo_reg  <= ge_lo ? BOUND_W'(ru_lo - {1'b0, tot}) : ru_lo[BOUND_W-1:0];
            prod_up_reg <= {prod_up_reg[PROD_W-2:0], ge_up};
            prod_lo_reg <= {prod_lo_reg[PROD_W-2:0], ge_lo};
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_byte_reg <= out_load_byte;
            out_last_reg <= cmd.fin_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;

    always_comb
    begin
        status.rn           = rn;
        status.guard_done   = (guard_reg == GUARD_LIMIT);
        status.pending_zero = (pend_reg == '0);
        status.pending_one  = (pend_reg == 8'd1);
        status.put_push     = put_push;
        status.part_push    = part_push;
        status.out_free     = out_free;
        status.div_last     = (div_cnt_reg == 6'd1);
    end

`ifndef SYNTHESIS
    a_bits_range: assert property (@(posedge clk) disable iff (!rst_n)
        (bits_reg != 4'd0) && (bits_reg <= BITS_FULL))
        else $error("bits_left out of range");

    a_drain_pending: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.drain |-> (pend_reg != '0))
        else $error("pending drain with no pending bits");

    a_out_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> out_free)
        else $error("output byte overwritten before it was taken");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> (rem_up_reg < tot) && (rem_lo_reg < tot))
        else $error("divider remainder not below divisor");
`endif

endmodule

// ===== src/arithmetic_encoder_16bit_unit.sv =====
// Top level of the 16-bit integer arithmetic encoder.
// Items arrive on the items channel: a load writes one cumulative count into the
// table, a start resets the coder bounds and counters, an encode narrows the
// interval for one symbol and renormalizes, and a finish flushes a final 1 bit,
// the pending bits, the partial byte when it is nonzero, and a zero byte flagged
// is_last. Code bytes leave on the codes channel, LSB first, through a single
// output register, so a new item can be taken while a byte still waits there. An
// encode reads the table and scales the upper and lower entries, runs the
// restoring divider (both quotients computed side by side, one bit per cycle),
// updates the bounds, then renormalizes, one step per shift and one per pending
// underflow bit sent, until the bounds call for a stop or the guard limit is hit.
// A finish puts the final bit, sends the pending bits, then the partial byte and
// the last byte. Any byte that finds the output register still full waits until
// the sink takes the old one. The count table is not initialized: entries must
// be loaded before use. The total_count register is written on the cfg channel,
// which is always ready, and must only be written while the encoder is idle.
module arithmetic_encoder_16bit_unit
    import aenc_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int MAX_BYTES   = MAX_BYTES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    aenc_item_if.sink   items,
    aenc_code_if.source codes,
    aenc_cfg_if.sink    cfg
);

    cmd_t    cmd;
    status_t status;

    // Sequencer: owns the item channel handshake
    aenc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (items.valid),
        .in_action (items.action),
        .in_ready  (items.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Datapath: table memory, bounds, dividers, byte packer, output register
    aenc_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .MAX_BYTES   (MAX_BYTES)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .in_action       (items.action),
        .in_symbol       (items.symbol),
        .in_table_value  (items.table_value),
        .cfg_valid       (cfg.valid),
        .cfg_ready       (cfg.ready),
        .cfg_total_count (cfg.total_count),
        .out_valid       (codes.valid),
        .out_ready       (codes.ready),
        .out_byte        (codes.out_byte),
        .out_last        (codes.is_last)
    );

endmodule
